@@ sv/rsd_pkg.sv @@
// Shared types, constants and helper functions for the run-length sprite span decoder.
// No dependencies; every other file of the block imports this package.

package rsd_pkg;

   // Largest sprite supported; the position counters are sized from these.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WID_W = COL_W + 1;
   localparam int HGT_W = ROW_W + 1;

   // Width of the comparison between a decoded count and the pixels left in the row.
   localparam int CMP_W = (WID_W > 8) ? WID_W : 8;
   localparam int ADV_W = CMP_W + 1;

   // Depth of both request and result queues (a power of two).
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QFILL_W = $clog2(QDEPTH + 1);

   // Configuration port.
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_LAYOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 2'd2;

   // Code layouts; the reserved code decodes as layout A.
   localparam logic [1:0] LAYOUT_A        = 2'd0;
   localparam logic [1:0] LAYOUT_B        = 2'd1;
   localparam logic [1:0] LAYOUT_C        = 2'd2;
   localparam logic [1:0] LAYOUT_RESERVED = 2'd3;

   // Span kinds on the result channel.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_SKIP    = 2'd1;
   localparam logic [1:0] KIND_RUN     = 2'd2;
   localparam logic [1:0] KIND_LITERAL = 2'd3;

   typedef enum logic [2:0] {
      CL_SKIP,
      CL_LIT,
      CL_RUN,
      CL_SKIPROW,
      CL_LITROW
   } code_class_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CODE,
      PH_LIT,
      PH_LITROW,
      PH_RUNVAL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       start_sprite;
   } req_type;

   typedef struct packed {
      logic [1:0]  span_kind;
      logic [9:0]  span_column;
      logic [9:0]  span_row;
      logic [10:0] span_count;
      logic [7:0]  add_value;
      logic        row_done;
      logic        sprite_done;
      logic        overrun;
   } rsp_type;

   // A request after classification, as passed from the front to the back.
   typedef struct packed {
      logic [7:0]     code_byte;
      logic           start_sprite;
      code_class_type code_class;
      logic [7:0]     run_count;
   } cmd_type;

   // Width and height limited to the supported range; zero acts as one.
   function automatic logic [WID_W-1:0] clamp_width(input logic [CSR_W-1:0] v);
      logic [WID_W-1:0] r;
      if (v == '0) begin
         r = WID_W'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         r = WID_W'(MAX_WIDTH);
      end else begin
         r = WID_W'(v);
      end
      return r;
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [CSR_W-1:0] v);
      logic [HGT_W-1:0] r;
      if (v == '0) begin
         r = HGT_W'(1);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = HGT_W'(MAX_HEIGHT);
      end else begin
         r = HGT_W'(v);
      end
      return r;
   endfunction

endpackage

@@ sv/rsd_front.sv @@
// Front end: accepts request bytes and classifies each one under the active code layout.
// Depends on rsd_pkg; feeds rsd_cmd_queue.

module rsd_front import rsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   input  logic [1:0] csr_layout,
   output logic       cmd_push,
   output cmd_type    cmd_data,
   input  logic       cmd_full
);

   logic [1:0]     layout_ff;
   logic [1:0]     layout_in;
   logic [1:0]     eff_layout;
   logic           accept;
   code_class_type cls;
   logic [7:0]     cnt;
   logic           use_special;
   logic [6:0]     special_n;
   logic [7:0]     b;

   assign req_full = cmd_full;
   assign accept   = req_push & ~cmd_full;
   assign cmd_push = accept;
   assign b        = req_data.code_byte;

   // A sprite start takes the layout from the register; the reserved code acts as layout A.
   always_comb begin
      eff_layout = layout_ff;
      if (req_data.start_sprite) begin
         eff_layout = (csr_layout == LAYOUT_RESERVED) ? LAYOUT_A : csr_layout;
      end
      layout_in = accept ? eff_layout : layout_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_A;
      end else begin
         layout_ff <= layout_in;
      end
   end

   // Classify the byte. The count is only meaningful for skips, literals and runs.
   always_comb begin
      cls         = CL_SKIP;
      cnt         = {2'b00, b[5:0]} + 8'd1;
      use_special = 1'b0;
      special_n   = 7'd0;
      case (eff_layout)
         LAYOUT_B: begin
            if (!b[7]) begin
               use_special = 1'b1;
               special_n   = b[6:0];
            end else if (b[6]) begin
               cls = CL_LIT;
            end else begin
               cls = CL_SKIP;
            end
         end
         LAYOUT_C: begin
            if (!b[7]) begin
               cls = CL_LIT;
               cnt = {1'b0, b[6:0]} + 8'd1;
            end else if (!b[6]) begin
               cls = CL_SKIP;
            end else begin
               use_special = 1'b1;
               special_n   = {1'b0, b[5:0]};
            end
         end
         default: begin
            if (!b[7]) begin
               cls = CL_SKIP;
               cnt = {1'b0, b[6:0]} + 8'd1;
            end else if (!b[6]) begin
               cls = CL_LIT;
            end else begin
               use_special = 1'b1;
               special_n   = {1'b0, b[5:0]};
            end
         end
      endcase
      // Special codes: skip the rest of the row, literal rest of the row, or a run.
      if (use_special) begin
         if (special_n == 7'd0) begin
            cls = CL_SKIPROW;
         end else if (special_n == 7'd1) begin
            cls = CL_LITROW;
         end else begin
            cls = CL_RUN;
            cnt = {1'b0, special_n} + 8'd1;
         end
      end
   end

   always_comb begin
      cmd_data.code_byte    = b;
      cmd_data.start_sprite = req_data.start_sprite;
      cmd_data.code_class   = cls;
      cmd_data.run_count    = cnt;
   end

endmodule

@@ sv/rsd_cmd_queue.sv @@
// Short queue of classified requests between the front and the back.
// Depends on rsd_pkg.

module rsd_cmd_queue import rsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff;
   logic [QFILL_W-1:0]   fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (fill_ff == QFILL_W'(QDEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/rsd_rsp_queue.sv @@
// Result queue: holds finished span commands until the consumer pops them.
// Depends on rsd_pkg.

module rsd_rsp_queue import rsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    pop,
   output rsp_type pop_data,
   output logic    empty
);

   rsp_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff;
   logic [QFILL_W-1:0]   fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (fill_ff == QFILL_W'(QDEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/rsd_back.sv @@
// Back end: tracks decode phase, column and row, and turns each classified request into a span.
// Depends on rsd_pkg; reads rsd_cmd_queue and writes rsd_rsp_queue.

module rsd_back import rsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  logic [CSR_W-1:0] csr_width,
   input  logic [CSR_W-1:0] csr_height,
   output logic             rsp_push,
   output rsp_type          rsp_data,
   input  logic             rsp_full
);

   phase_type        phase_ff;
   phase_type        phase_in;
   logic [7:0]       pend_ff;
   logic [7:0]       pend_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [WID_W-1:0] width_ff;
   logic [WID_W-1:0] width_in;
   logic [HGT_W-1:0] height_ff;
   logic [HGT_W-1:0] height_in;

   logic             fire;
   phase_type        eff_phase;
   logic [7:0]       eff_pend;
   logic [COL_W-1:0] eff_col;
   logic [ROW_W-1:0] eff_row;
   logic [WID_W-1:0] eff_width;
   logic [HGT_W-1:0] eff_height;
   logic [WID_W-1:0] rem;
   logic [CMP_W-1:0] rem_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             too_long;
   logic [CMP_W-1:0] fit_cnt;
   logic [CMP_W-1:0] adv_cnt;
   logic [ADV_W-1:0] new_col;
   logic             row_end;
   logic             last_row;
   logic [7:0]       pend_next;
   logic             outside;

   assign fire     = cmd_valid & ~rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   // A sprite start resets the position and takes the size from the registers.
   always_comb begin
      eff_phase  = phase_ff;
      eff_pend   = pend_ff;
      eff_col    = col_ff;
      eff_row    = row_ff;
      eff_width  = width_ff;
      eff_height = height_ff;
      if (cmd_data.start_sprite) begin
         eff_phase  = PH_CODE;
         eff_pend   = 8'd0;
         eff_col    = '0;
         eff_row    = '0;
         eff_width  = clamp_width(csr_width);
         eff_height = clamp_height(csr_height);
      end
   end

   // Pixels left in the row, and the decoded count limited to them.
   always_comb begin
      rem      = eff_width - WID_W'(eff_col);
      rem_ext  = CMP_W'(rem);
      cnt_ext  = CMP_W'(cmd_data.run_count);
      too_long = (cnt_ext > rem_ext);
      fit_cnt  = too_long ? rem_ext : cnt_ext;
   end

   // How far this request moves the column, the span it shows and the count left pending.
   always_comb begin
      adv_cnt             = '0;
      pend_next           = eff_pend;
      outside             = 1'b0;
      rsp_data.span_kind  = KIND_HEADER;
      rsp_data.span_count = '0;
      rsp_data.add_value  = 8'd0;
      rsp_data.overrun    = 1'b0;
      case (eff_phase)
         PH_CODE: begin
            case (cmd_data.code_class)
               CL_SKIPROW: begin
                  rsp_data.span_kind  = KIND_SKIP;
                  rsp_data.span_count = 11'(rem);
                  adv_cnt             = rem_ext;
               end
               CL_SKIP: begin
                  rsp_data.span_kind  = KIND_SKIP;
                  rsp_data.span_count = 11'(fit_cnt);
                  rsp_data.overrun    = too_long;
                  adv_cnt             = fit_cnt;
               end
               CL_LIT, CL_RUN: begin
                  rsp_data.overrun = too_long;
                  pend_next        = 8'(fit_cnt);
               end
               default: begin
                  rsp_data.span_kind = KIND_HEADER;
               end
            endcase
         end
         PH_LIT: begin
            rsp_data.span_kind  = KIND_LITERAL;
            rsp_data.span_count = 11'd1;
            rsp_data.add_value  = cmd_data.code_byte;
            pend_next           = eff_pend - 8'd1;
            adv_cnt             = CMP_W'(1);
         end
         PH_LITROW: begin
            rsp_data.span_kind  = KIND_LITERAL;
            rsp_data.span_count = 11'd1;
            rsp_data.add_value  = cmd_data.code_byte;
            adv_cnt             = CMP_W'(1);
         end
         PH_RUNVAL: begin
            rsp_data.span_kind  = KIND_RUN;
            rsp_data.span_count = 11'(eff_pend);
            rsp_data.add_value  = cmd_data.code_byte;
            pend_next           = 8'd0;
            adv_cnt             = CMP_W'(eff_pend);
         end
         default: begin
            // Byte outside a sprite: an empty header with the overrun flag.
            outside          = 1'b1;
            rsp_data.overrun = 1'b1;
         end
      endcase
      // Row and sprite end detection.
      new_col  = ADV_W'(eff_col) + ADV_W'(adv_cnt);
      row_end  = (new_col >= ADV_W'(eff_width));
      last_row = ((HGT_W'(eff_row) + HGT_W'(1)) >= eff_height);
      rsp_data.span_column = outside ? 10'd0 : 10'(eff_col);
      rsp_data.span_row    = outside ? 10'd0 : 10'(eff_row);
      rsp_data.row_done    = row_end;
      rsp_data.sprite_done = row_end & last_row;
   end

   // Next decode phase.
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (eff_phase)
            PH_CODE: begin
               case (cmd_data.code_class)
                  CL_LITROW: phase_in = PH_LITROW;
                  CL_LIT:    phase_in = PH_LIT;
                  CL_RUN:    phase_in = PH_RUNVAL;
                  default:   phase_in = PH_CODE;
               endcase
            end
            PH_LIT:    phase_in = (pend_next == 8'd0) ? PH_CODE : PH_LIT;
            PH_LITROW: phase_in = PH_LITROW;
            PH_RUNVAL: phase_in = PH_CODE;
            default:   phase_in = eff_phase;
         endcase
         if (row_end) begin
            phase_in = last_row ? PH_DONE : PH_CODE;
         end
      end
   end

   // Position, pending count and latched size.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (fire) begin
         col_in    = row_end ? '0 : COL_W'(new_col);
         row_in    = row_end ? eff_row + ROW_W'(1) : eff_row;
         pend_in   = pend_next;
         width_in  = eff_width;
         height_in = eff_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pend_ff   <= 8'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         width_ff  <= WID_W'(1);
         height_ff <= HGT_W'(1);
      end else begin
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

endmodule

@@ sv/rle_sprite_span_decoder.sv @@
// A request is held in the command queue and then in the result queue before its span
// is visible on the result port.
// Throughput: one request per cycle unless the result queue fills and stalls the back end.
// The two-entry queues between front, back and the result port let either side stall alone.
// Reset (synchronous, active high) empties both queues, sets the decoder idle at row 0,
// column 0, and returns the registers to layout A, width 1 and height 1.
// Top level of the run-length sprite span decoder; depends on rsd_pkg and all rsd_ modules.

module rle_sprite_span_decoder import rsd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [1:0]       layout_ff;
   logic [1:0]       layout_in;
   logic [CSR_W-1:0] width_ff;
   logic [CSR_W-1:0] width_in;
   logic [CSR_W-1:0] height_ff;
   logic [CSR_W-1:0] height_in;

   logic    cmd_push;
   logic    cmd_full;
   cmd_type cmd_in_data;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_out_data;
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_in_data;

   // Configuration registers; writes to an unused index are dropped.
   always_comb begin
      layout_in = layout_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CODE_LAYOUT:   layout_in = csr_wdata[1:0];
            CSR_SPRITE_WIDTH:  width_in  = csr_wdata;
            CSR_SPRITE_HEIGHT: height_in = csr_wdata;
            default:           layout_in = layout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_A;
         width_ff  <= CSR_W'(1);
         height_ff <= CSR_W'(1);
      end else begin
         layout_ff <= layout_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Front end: accept and classify.
   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_layout (layout_ff),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in_data),
      .cmd_full   (cmd_full)
   );

   // Queue between the two halves.
   rsd_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // Back end: decode state and span generation.
   rsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (~cmd_empty),
      .cmd_data   (cmd_out_data),
      .cmd_pop    (cmd_pop),
      .csr_width  (width_ff),
      .csr_height (height_ff),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in_data),
      .rsp_full   (rsp_full)
   );

   // Result queue facing the consumer.
   rsd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ sv/rsd_checker.sv @@
// Port-level checks for the run-length sprite span decoder, bound to the top level.
// Depends on rsd_pkg and rle_sprite_span_decoder.

module rsd_checker import rsd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input req_type              req_data,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input rsp_type              rsp_data,
   input logic                 csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_W-1:0]     csr_wdata
);

   // After reset no result is waiting and a request can be taken.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("results pending or input full after reset");

   // A waiting result is not dropped while it is not popped.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result vanished");

   // A sprite can only end on a span that ends its row.
   a_sprite_row: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.sprite_done |-> rsp_data.row_done)
      else $error("sprite done without row done");

   // Headers never carry pixels.
   a_header_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.span_kind == KIND_HEADER) |->
         (rsp_data.span_count == 11'd0) && (rsp_data.add_value == 8'd0))
      else $error("header span carries pixels");

endmodule

bind rle_sprite_span_decoder rsd_checker u_rsd_checker (.*);
